// ===== rtl/core/pmsq_pkg.sv =====
package pmsq_pkg;

  localparam int unsigned NumCh    = 3;
  localparam int unsigned SampleW  = 8;
  localparam int unsigned MeanW    = 16;
  localparam int unsigned ScaleW   = 20;
  localparam int unsigned DiffW    = SampleW + 9;        // signed Q9.8 difference
  localparam int unsigned MagW     = DiffW - 1;          // magnitude never exceeds 65535
  localparam int unsigned ProdW    = MagW + ScaleW;      // 24 fraction bits
  localparam int unsigned FracBits = 24;
  localparam int unsigned QW       = ProdW - FracBits;   // integer part of the product
  localparam int unsigned ResW     = 8;

  localparam int unsigned DataW    = NumCh * SampleW;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned RegIdxW  = 3;

  // Register indexes; the byte address is four times the index.
  localparam logic [RegIdxW-1:0] RegMeanFirst   = 3'd0;
  localparam logic [RegIdxW-1:0] RegMeanSecond  = 3'd1;
  localparam logic [RegIdxW-1:0] RegMeanThird   = 3'd2;
  localparam logic [RegIdxW-1:0] RegScaleFirst  = 3'd3;
  localparam logic [RegIdxW-1:0] RegScaleSecond = 3'd4;
  localparam logic [RegIdxW-1:0] RegScaleThird  = 3'd5;
  localparam logic [RegIdxW-1:0] RegRoundMode   = 3'd6;
  localparam logic [RegIdxW-1:0] RegSwapOrder   = 3'd7;

  localparam logic [ScaleW-1:0] ScaleReset = 20'd65536;

  localparam logic signed [ResW-1:0] ResMin = -8'sd128;
  localparam logic signed [ResW-1:0] ResMax = 8'sd127;

  typedef struct packed {
    logic [NumCh-1:0][MeanW-1:0]  mean;
    logic [NumCh-1:0][ScaleW-1:0] scale;
    logic                         round_mode;
    logic                         swap_order;
  } cfg_t;

endpackage

// ===== rtl/core/pixel_mean_scale_quantizer.sv =====
// An accepted pixel passes through the difference, product and result registers in
// turn; the result register drives m_tdata.
// Throughput: one pixel per cycle unless the output stalls; three register stages
// per channel (difference, 16x20 multiply, truncate or round and saturate) advance
// together under one enable. A stall at the output holds every stage in place.
// Reset (rst_ni, asynchronous, active low) clears the stage valid bits and loads
// the register defaults: means 0, scales 1.0, truncate mode, natural channel order.
module pixel_mean_scale_quantizer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [pmsq_pkg::DataW-1:0]        s_tdata,   // sample_first, sample_second, sample_third
  input  logic                              s_tlast,   // frame_end_in
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pmsq_pkg::DataW-1:0]        m_tdata,   // result_first, result_second, result_third
  output logic                              m_tlast,   // frame_end_out
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pmsq_pkg::ApbAddrW-1:0]     paddr,
  input  logic [pmsq_pkg::ApbDataW-1:0]     pwdata,
  output logic [pmsq_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);

  localparam int unsigned NumCh   = pmsq_pkg::NumCh;
  localparam int unsigned SampleW = pmsq_pkg::SampleW;
  localparam int unsigned ResW    = pmsq_pkg::ResW;

  pmsq_pkg::cfg_t cfg;

  pmsq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The whole pipe moves whenever the output register is free or being drained.
  logic       en;
  logic [2:0] vld_q, vld_d;
  logic [2:0] last_q;

  assign en       = !vld_q[2] || m_tready;
  assign s_tready = en;
  assign vld_d    = {vld_q[1:0], s_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q <= {last_q[1:0], s_tlast};
    end
  end

  // Lane k works on input channel 2-k with that channel's mean and scale when swapped.
  for (genvar k = 0; k < NumCh; k++) begin : g_lane
    localparam int unsigned Src = NumCh - 1 - k;
    logic [SampleW-1:0]          smp;
    logic [pmsq_pkg::MeanW-1:0]  mean;
    logic [pmsq_pkg::ScaleW-1:0] scale;

    assign smp   = cfg.swap_order ? s_tdata[Src*SampleW +: SampleW]
                                  : s_tdata[k*SampleW +: SampleW];
    assign mean  = cfg.swap_order ? cfg.mean[Src]  : cfg.mean[k];
    assign scale = cfg.swap_order ? cfg.scale[Src] : cfg.scale[k];

    pmsq_lane u_lane (
      .clk_i        (clk_i),
      .en_i         (en),
      .sample_i     (smp),
      .mean_i       (mean),
      .scale_i      (scale),
      .round_mode_i (cfg.round_mode),
      .result_o     (m_tdata[k*ResW +: ResW])
    );
  end

  assign m_tvalid = vld_q[2];
  assign m_tlast  = last_q[2];

endmodule

// ===== rtl/core/pmsq_regs.sv =====
module pmsq_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pmsq_pkg::ApbAddrW-1:0]     paddr,
  input  logic [pmsq_pkg::ApbDataW-1:0]     pwdata,
  output logic [pmsq_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready,
  output pmsq_pkg::cfg_t                    cfg_o
);

  pmsq_pkg::cfg_t                   cfg_q, cfg_d;
  logic [pmsq_pkg::RegIdxW-1:0]     idx;
  logic                             wr_en;

  assign idx    = paddr[pmsq_pkg::ApbAddrW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        pmsq_pkg::RegMeanFirst:   cfg_d.mean[0]  = pwdata[pmsq_pkg::MeanW-1:0];
        pmsq_pkg::RegMeanSecond:  cfg_d.mean[1]  = pwdata[pmsq_pkg::MeanW-1:0];
        pmsq_pkg::RegMeanThird:   cfg_d.mean[2]  = pwdata[pmsq_pkg::MeanW-1:0];
        pmsq_pkg::RegScaleFirst:  cfg_d.scale[0] = pwdata[pmsq_pkg::ScaleW-1:0];
        pmsq_pkg::RegScaleSecond: cfg_d.scale[1] = pwdata[pmsq_pkg::ScaleW-1:0];
        pmsq_pkg::RegScaleThird:  cfg_d.scale[2] = pwdata[pmsq_pkg::ScaleW-1:0];
        pmsq_pkg::RegRoundMode:   cfg_d.round_mode = pwdata[0];
        pmsq_pkg::RegSwapOrder:   cfg_d.swap_order = pwdata[0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      pmsq_pkg::RegMeanFirst:   prdata = 32'(cfg_q.mean[0]);
      pmsq_pkg::RegMeanSecond:  prdata = 32'(cfg_q.mean[1]);
      pmsq_pkg::RegMeanThird:   prdata = 32'(cfg_q.mean[2]);
      pmsq_pkg::RegScaleFirst:  prdata = 32'(cfg_q.scale[0]);
      pmsq_pkg::RegScaleSecond: prdata = 32'(cfg_q.scale[1]);
      pmsq_pkg::RegScaleThird:  prdata = 32'(cfg_q.scale[2]);
      pmsq_pkg::RegRoundMode:   prdata = 32'(cfg_q.round_mode);
      pmsq_pkg::RegSwapOrder:   prdata = 32'(cfg_q.swap_order);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mean       <= '0;
      cfg_q.scale      <= {pmsq_pkg::NumCh{pmsq_pkg::ScaleReset}};
      cfg_q.round_mode <= 1'b0;
      cfg_q.swap_order <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/core/pmsq_lane.sv =====
module pmsq_lane (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [pmsq_pkg::SampleW-1:0]      sample_i,
  input  logic [pmsq_pkg::MeanW-1:0]        mean_i,
  input  logic [pmsq_pkg::ScaleW-1:0]       scale_i,
  input  logic                              round_mode_i,
  output logic [pmsq_pkg::ResW-1:0]         result_o
);

  localparam int unsigned DiffW = pmsq_pkg::DiffW;
  localparam int unsigned MagW  = pmsq_pkg::MagW;
  localparam int unsigned ProdW = pmsq_pkg::ProdW;
  localparam int unsigned QW    = pmsq_pkg::QW;
  localparam int unsigned ResW  = pmsq_pkg::ResW;
  localparam int unsigned FracB = pmsq_pkg::FracBits;

  // Stage 1: sign and magnitude of sample*256 - mean.
  logic [DiffW-1:0] diff, diff_neg;
  logic             neg1_d, neg1_q;
  logic [MagW-1:0]  mag1_d, mag1_q;

  assign diff     = {1'b0, sample_i, 8'b0} - {1'b0, mean_i};
  assign diff_neg = '0 - diff;
  assign neg1_d   = diff[DiffW-1];
  assign mag1_d   = neg1_d ? diff_neg[MagW-1:0] : diff[MagW-1:0];

  // Stage 2: unsigned product with 24 fraction bits.
  logic             neg2_q;
  logic [ProdW-1:0] prod2_d, prod2_q;

  assign prod2_d = ProdW'(mag1_q) * ProdW'(scale_i);

  // Stage 3: truncate and wrap, or round half away and saturate.
  logic [QW-1:0]   q_trunc;
  logic [QW+1:0]   rnd_sum;
  logic [QW:0]     q_rnd;
  logic [ResW-1:0] mag_out;
  logic [ResW-1:0] res3_d, res3_q;

  assign q_trunc = prod2_q[ProdW-1:FracB];
  assign rnd_sum = {1'b0, prod2_q[ProdW-1:FracB-1]} + (QW+2)'(1);
  assign q_rnd   = rnd_sum[QW+1:1];

  always_comb begin
    if (!round_mode_i) begin
      mag_out = q_trunc[ResW-1:0];
    end else if (neg2_q) begin
      mag_out = (q_rnd > (QW+1)'(128)) ? 8'd128 : q_rnd[ResW-1:0];
    end else begin
      mag_out = (q_rnd > (QW+1)'(127)) ? 8'(pmsq_pkg::ResMax) : q_rnd[ResW-1:0];
    end
    res3_d = neg2_q ? (8'd0 - mag_out) : mag_out;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q  <= neg1_d;
      mag1_q  <= mag1_d;
      neg2_q  <= neg1_q;
      prod2_q <= prod2_d;
      res3_q  <= res3_d;
    end
  end

  assign result_o = res3_q;

endmodule

// ===== tb/pixel_norm_checker.sv =====
`timescale 1ns / 100ps

module pixel_norm_checker
  import pmsq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [DataW-1:0]    s_tdata,
  input  logic                s_tlast,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [DataW-1:0]    m_tdata,
  input  logic                m_tlast,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  input  logic [ApbDataW-1:0] prdata,
  input  logic                pready,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o
);

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             last;
  } norm_pixel_t;

  norm_pixel_t       expected_pixels[$];
  norm_pixel_t       want;
  norm_pixel_t       got;
  logic [MeanW-1:0]  mean_q  [NumCh];
  logic [ScaleW-1:0] scale_q [NumCh];
  logic              round_q;
  logic              swap_q;
  logic [RegIdxW-1:0]  reg_idx;
  logic [ApbDataW-1:0] reg_want;
  int unsigned         src;

  // Exact (sample - mean) * scale with 24 fraction bits, reduced to a signed byte.
  function automatic logic [ResW-1:0] quantize_channel(input logic [SampleW-1:0] smp,
                                                       input logic [MeanW-1:0]   mean,
                                                       input logic [ScaleW-1:0]  scale,
                                                       input logic               rnd);
    logic signed [MeanW+2:0] diff;
    logic                    neg;
    logic [MeanW:0]          mag;
    logic [63:0]             prod;
    logic [63:0]             q;
    diff = $signed({3'b000, smp, 8'h00}) - $signed({3'b000, mean});
    neg  = diff[MeanW+2];
    mag  = neg ? (MeanW+1)'(-diff) : (MeanW+1)'(diff);
    prod = 64'(mag) * 64'(scale);
    if (!rnd) begin
      q = prod >> FracBits;
    end else begin
      q = (prod + (64'd1 << (FracBits - 1))) >> FracBits;
      if (neg && q > 64'(ResMax) + 64'd1) begin
        q = 64'(ResMax) + 64'd1;
      end else if (!neg && q > 64'(ResMax)) begin
        q = 64'(ResMax);
      end
    end
    if (neg) begin
      q = 64'd0 - q;
    end
    return q[ResW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumCh; c++) begin
        mean_q[c]  <= '0;
        scale_q[c] <= ScaleReset;
      end
      round_q <= 1'b0;
      swap_q  <= 1'b0;
    end else begin
      reg_idx = paddr[ApbAddrW-1:2];
      if (psel && penable && pready && pwrite) begin
        case (reg_idx)
          RegMeanFirst:   mean_q[0]  <= pwdata[MeanW-1:0];
          RegMeanSecond:  mean_q[1]  <= pwdata[MeanW-1:0];
          RegMeanThird:   mean_q[2]  <= pwdata[MeanW-1:0];
          RegScaleFirst:  scale_q[0] <= pwdata[ScaleW-1:0];
          RegScaleSecond: scale_q[1] <= pwdata[ScaleW-1:0];
          RegScaleThird:  scale_q[2] <= pwdata[ScaleW-1:0];
          RegRoundMode:   round_q    <= pwdata[0];
          RegSwapOrder:   swap_q     <= pwdata[0];
          default: ;
        endcase
      end
      if (psel && penable && pready && !pwrite) begin
        case (reg_idx)
          RegMeanFirst:   reg_want = ApbDataW'(mean_q[0]);
          RegMeanSecond:  reg_want = ApbDataW'(mean_q[1]);
          RegMeanThird:   reg_want = ApbDataW'(mean_q[2]);
          RegScaleFirst:  reg_want = ApbDataW'(scale_q[0]);
          RegScaleSecond: reg_want = ApbDataW'(scale_q[1]);
          RegScaleThird:  reg_want = ApbDataW'(scale_q[2]);
          RegRoundMode:   reg_want = ApbDataW'(round_q);
          default:        reg_want = ApbDataW'(swap_q);
        endcase
        if (prdata !== reg_want) begin
          fail_count_o++;
          $display("%0t: register %0d read expected 0x%0h got 0x%0h",
                   $time, reg_idx, reg_want, prdata);
        end
      end

      if (s_tvalid && s_tready) begin
        for (int k = 0; k < NumCh; k++) begin
          src = swap_q ? NumCh - 1 - k : k;
          want.data[k*ResW +: ResW] = quantize_channel(s_tdata[src*SampleW +: SampleW],
                                                       mean_q[src], scale_q[src], round_q);
        end
        want.last = s_tlast;
        expected_pixels.insert(expected_pixels.size(), want);
      end

      if (m_tvalid && m_tready) begin
        if (expected_pixels.size() == 0) begin
          fail_count_o++;
          $display("%0t: result beat with nothing expected, got data 0x%0h last %0b",
                   $time, m_tdata, m_tlast);
        end else begin
          want = expected_pixels.pop_front();
          got  = '{data: m_tdata, last: m_tlast};
          checked_o++;
          for (int k = 0; k < NumCh; k++) begin
            if (got.data[k*ResW +: ResW] !== want.data[k*ResW +: ResW]) begin
              fail_count_o++;
              $display("%0t: result channel %0d expected %0d got %0d", $time, k,
                       $signed(want.data[k*ResW +: ResW]),
                       $signed(got.data[k*ResW +: ResW]));
            end
          end
          if (got.last !== want.last) begin
            fail_count_o++;
            $display("%0t: frame end expected %0b got %0b", $time, want.last, got.last);
          end
        end
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import pmsq_pkg::*;

  localparam int RandPhases    = 12;
  localparam int PixelsPerPhase = 120;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [DataW-1:0]    s_tdata  = '0;   // sample_first, sample_second, sample_third
  logic                s_tlast  = 1'b0; // frame_end_in
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [DataW-1:0]    m_tdata;         // result_first, result_second, result_third
  logic                m_tlast;         // frame_end_out
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [ApbAddrW-1:0] paddr    = '0;
  logic [ApbDataW-1:0] pwdata   = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int fail_count;
  int pending;
  int checked;
  int pixels_sent    = 0;
  int settings_used  = 0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;

  logic [MeanW-1:0]  cfg_mean  [NumCh];
  logic [ScaleW-1:0] cfg_scale [NumCh];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still outstanding", pending);
    $display("CHECK FAILED");
    $finish;
  end

  pixel_mean_scale_quantizer i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  pixel_norm_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic reg_access(input logic wr, input logic [RegIdxW-1:0] idx,
                            input logic [ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [SampleW-1:0] a, input logic [SampleW-1:0] b,
                            input logic [SampleW-1:0] c, input logic last);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {c, b, a};
    s_tlast  <= last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    pixels_sent++;
  endtask

  // Stop the input stream and let every outstanding beat come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (6) @(posedge clk_i);
  endtask

  // Writes every register, with junk in the unused upper bits now and then, and reads back.
  task automatic apply_settings(input logic [MeanW-1:0] m0, input logic [MeanW-1:0] m1,
                                input logic [MeanW-1:0] m2, input logic [ScaleW-1:0] s0,
                                input logic [ScaleW-1:0] s1, input logic [ScaleW-1:0] s2,
                                input logic rnd, input logic swp);
    logic [ApbDataW-1:0] junk;
    cfg_mean  = '{m0, m1, m2};
    cfg_scale = '{s0, s1, s2};
    drain();
    for (int c = 0; c < NumCh; c++) begin
      junk = ($urandom_range(0, 2) == 0) ? $urandom() : '0;
      reg_access(1'b1, RegIdxW'(RegMeanFirst + c), {junk[ApbDataW-1:MeanW], cfg_mean[c]});
      junk = ($urandom_range(0, 2) == 0) ? $urandom() : '0;
      reg_access(1'b1, RegIdxW'(RegScaleFirst + c),
                 {junk[ApbDataW-1:ScaleW], cfg_scale[c]});
    end
    junk = ($urandom_range(0, 2) == 0) ? $urandom() : '0;
    reg_access(1'b1, RegRoundMode, {junk[ApbDataW-1:1], rnd});
    junk = ($urandom_range(0, 2) == 0) ? $urandom() : '0;
    reg_access(1'b1, RegSwapOrder, {junk[ApbDataW-1:1], swp});
    for (int i = 0; i < 8; i++) begin
      reg_access(1'b0, RegIdxW'(i), '0);
    end
    settings_used++;
  endtask

  initial begin
    logic [MeanW-1:0]   m [NumCh];
    logic [ScaleW-1:0]  s [NumCh];
    logic [SampleW-1:0] smp [NumCh];

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_gap_pct   = 14;
    recv_stall_pct = 75;

    // Reset values: truncate, unit scale, zero mean; samples above 127 wrap negative.
    for (int i = 0; i < 8; i++) begin
      reg_access(1'b0, RegIdxW'(i), '0);
    end
    cfg_mean  = '{16'h0000, 16'h0000, 16'h0000};
    cfg_scale = '{ScaleReset, ScaleReset, ScaleReset};
    settings_used++;
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd128, 8'd127, 8'd1, 1'b0);
    send_pixel(8'd170, 8'd85, 8'd200, 1'b1);

    // Round mode at unit scale: half-way ties on the first channel, saturation elsewhere.
    apply_settings(16'h7F80, 16'hFFFF, 16'h0000, ScaleReset, ScaleReset, ScaleReset,
                   1'b1, 1'b0);
    send_pixel(8'd127, 8'd127, 8'd127, 1'b0);
    send_pixel(8'd128, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd126, 8'd254, 8'd127, 1'b1);

    // Truncate with reversed order: zero scale, largest scale and wrap-around.
    apply_settings(16'h0000, 16'h8000, 16'h00FF, 20'h00000, 20'hFFFFF, 20'h08000,
                   1'b0, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd128, 8'd0, 1'b1);
    send_pixel(8'd77, 8'd129, 8'd3, 1'b0);
    send_pixel(8'd200, 8'd127, 8'd1, 1'b0);

    // Largest mean and scale in round mode, reversed order.
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
                   1'b1, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);

    // Zero scale in round mode.
    apply_settings(16'h1234, 16'hFFFF, 16'h0080, 20'h00000, 20'h00000, 20'h00000,
                   1'b1, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd128, 1'b1);

    for (int p = 0; p < RandPhases; p++) begin
      for (int c = 0; c < NumCh; c++) begin
        case ($urandom_range(0, 5))
          0:       m[c] = '0;
          1:       m[c] = '1;
          2:       m[c] = {8'($urandom_range(0, 255)), 8'h80};
          default: m[c] = MeanW'($urandom());
        endcase
        case ($urandom_range(0, 7))
          0:       s[c] = '0;
          1:       s[c] = '1;
          2, 3:    s[c] = ScaleW'($urandom());
          default: s[c] = ScaleW'($urandom_range(32'h04000, 32'h30000));
        endcase
      end
      apply_settings(m[0], m[1], m[2], s[0], s[1], s[2], 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      if (p < RandPhases / 3) begin
        send_gap_pct   = 14;
        recv_stall_pct = 75;
      end else if (p < 2 * RandPhases / 3) begin
        send_gap_pct   = 75;
        recv_stall_pct = 14;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      for (int n = 0; n < PixelsPerPhase; n++) begin
        // A quarter of the samples sit close to the channel mean, where rounding matters.
        for (int c = 0; c < NumCh; c++) begin
          if ($urandom_range(0, 3) == 0) begin
            smp[c] = cfg_mean[c][MeanW-1:8] + 8'($urandom_range(0, 4)) - 8'd2;
          end else begin
            smp[c] = SampleW'($urandom_range(0, 255));
          end
        end
        send_pixel(smp[0], smp[1], smp[2], ($urandom_range(0, 15) == 0));
      end
    end

    drain();
    @(negedge clk_i);
    $display("Sent %0d pixels under %0d register settings; %0d results checked.",
             pixels_sent, settings_used, checked);
    $display("Both rounding modes, both channel orders, and stalls on either side were used.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
